// ===== rtl/core/gba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gba_pkg;

   localparam int EST_W           = 16;
   localparam int SUM_W           = 32;
   localparam int ARM_OUT_W       = 2;
   localparam int DEF_NUM_ARMS    = 4;
   localparam int DEF_COUNT_WIDTH = 16;

   typedef logic signed [EST_W-1:0] est_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [ARM_OUT_W-1:0]    arm_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/greedy_bandit_agent_unit.sv =====
// One request in flight; req_ready returns with rsp_valid. The mean update runs a 16-step
// restoring divider, skipped on the first play of an arm, and the argmax scan reads the
// estimate memory one arm a cycle. The result register lets the next request in while a
// response still waits. Synchronous active-high reset clears the played flags, the running
// reward total, the current arm and the response valid.
`timescale 1ns / 1ps
`default_nettype none

module greedy_bandit_agent_unit
   import gba_pkg::*;
#(
   parameter int NUM_ARMS    = DEF_NUM_ARMS,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire est_type     req_reward,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output arm_out_type      rsp_arm_played,
   output est_type          rsp_updated_estimate,
   output arm_out_type      rsp_next_arm,
   output sum_type          rsp_total_reward
);

   localparam int ARM_W   = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
   localparam int ARM_X_W = (ARM_W > ARM_OUT_W) ? ARM_W : ARM_OUT_W;
   localparam int STEP_W  = $clog2(EST_W);
   localparam logic [ARM_W-1:0]       LAST_ARM  = ARM_W'(NUM_ARMS - 1);
   localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(EST_W - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);
   localparam sum_type SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam sum_type SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_LAST  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // estimate and count memories
   est_type                est_mem [NUM_ARMS];
   logic [COUNT_WIDTH-1:0] cnt_mem [NUM_ARMS];

   logic [2:0]             state_ff, state_in;
   est_type                reward_ff, reward_in;
   logic [ARM_W-1:0]       cur_arm_ff, cur_arm_in;
   logic [NUM_ARMS-1:0]    played_ff, played_in;
   sum_type                sum_ff, sum_in;
   est_type                rd_est_ff;
   logic [COUNT_WIDTH-1:0] rd_cnt_ff;
   est_type                q_ff, q_in;
   logic                   first_ff, first_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0] cnt_new_ff, cnt_new_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [EST_W-1:0]       quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [ARM_W-1:0]       scan_ff, scan_in;
   logic [ARM_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   found_ff, found_in;
   logic [ARM_W-1:0]       best_idx_ff, best_idx_in;
   est_type                best_est_ff, best_est_in;
   est_type                est_res_ff, est_res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   arm_out_type            rsp_arm_ff, rsp_arm_in;
   est_type                rsp_est_ff, rsp_est_in;
   arm_out_type            rsp_next_ff, rsp_next_in;
   sum_type                rsp_sum_ff, rsp_sum_in;

   logic [ARM_W-1:0]       rd_addr;
   logic                   wr_en;
   est_type                wr_est;
   logic signed [EST_W:0]  diff;
   logic signed [EST_W:0]  mag;
   logic signed [SUM_W:0]  sum_ext;
   logic [COUNT_WIDTH:0]   rem_sh;
   logic [COUNT_WIDTH:0]   rem_sub;
   logic                   ge;
   logic signed [EST_W:0]  quo_s;
   logic signed [EST_W:0]  est_sum;
   logic [ARM_X_W-1:0]     cur_x;
   logic [ARM_X_W-1:0]     best_x;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         est_mem[cur_arm_ff] <= wr_est;
         cnt_mem[cur_arm_ff] <= cnt_new_ff;
      end
      rd_est_ff <= est_mem[rd_addr];
      rd_cnt_ff <= cnt_mem[rd_addr];
   end

   assign rd_addr = (state_ff == S_SCAN) ? scan_ff : cur_arm_ff;

   assign diff    = {reward_ff[EST_W-1], reward_ff} - {rd_est_ff[EST_W-1], rd_est_ff};
   assign mag     = diff[EST_W] ? -diff : diff;
   assign sum_ext = {sum_ff[SUM_W-1], sum_ff} + (SUM_W+1)'(reward_ff);
   assign rem_sh  = {rem_ff, quo_ff[EST_W-1]};
   assign rem_sub = rem_sh - {1'b0, cnt_new_ff};
   assign ge      = (rem_sh >= {1'b0, cnt_new_ff});
   assign quo_s   = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign est_sum = {q_ff[EST_W-1], q_ff} + quo_s;
   assign wr_est  = first_ff ? reward_ff : est_sum[EST_W-1:0];
   assign cur_x   = ARM_X_W'(cur_arm_ff);
   assign best_x  = ARM_X_W'(best_idx_ff);

   always_comb begin
      state_in     = state_ff;
      reward_in    = reward_ff;
      cur_arm_in   = cur_arm_ff;
      played_in    = played_ff;
      sum_in       = sum_ff;
      q_in         = q_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      cnt_new_in   = cnt_new_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = scan_ff;
      cmp_vld_in   = 1'b0;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_est_in  = best_est_ff;
      est_res_in   = est_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_arm_in   = rsp_arm_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_sum_in   = rsp_sum_ff;
      wr_en        = 1'b0;
      req_ready    = 1'b0;

      // argmax scan: first unplayed arm wins, else strictly greater estimate
      if (cmp_vld_ff && !found_ff) begin
         if (!played_ff[cmp_idx_ff]) begin
            found_in    = 1'b1;
            best_idx_in = cmp_idx_ff;
         end else if (cmp_idx_ff == '0 || rd_est_ff > best_est_ff) begin
            best_idx_in = cmp_idx_ff;
            best_est_in = rd_est_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               reward_in = req_reward;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            first_in = !played_ff[cur_arm_ff];
            q_in     = rd_est_ff;
            neg_in   = diff[EST_W];
            quo_in   = mag[EST_W-1:0];
            rem_in   = '0;
            step_in  = '0;
            if (!played_ff[cur_arm_ff])
               cnt_new_in = CNT_ONE;
            else if (rd_cnt_ff == CNT_MAX)
               cnt_new_in = rd_cnt_ff;
            else
               cnt_new_in = rd_cnt_ff + CNT_ONE;
            // clamp the running total on overflow
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
               sum_in = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
            else
               sum_in = sum_ext[SUM_W-1:0];
            state_in = played_ff[cur_arm_ff] ? S_DIV : S_WRITE;
         end
         S_DIV: begin
            rem_in  = ge ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            quo_in  = {quo_ff[EST_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP)
               state_in = S_WRITE;
         end
         S_WRITE: begin
            wr_en                 = 1'b1;
            played_in[cur_arm_ff] = 1'b1;
            est_res_in            = wr_est;
            scan_in               = '0;
            found_in              = 1'b0;
            state_in              = S_SCAN;
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (scan_ff == LAST_ARM)
               state_in = S_LAST;
            else
               scan_in = scan_ff + 1'b1;
         end
         S_LAST: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_arm_in   = cur_x[ARM_OUT_W-1:0];
               rsp_est_in   = est_res_ff;
               rsp_next_in  = best_x[ARM_OUT_W-1:0];
               rsp_sum_in   = sum_ff;
               cur_arm_in   = best_idx_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_arm_ff   <= '0;
         played_ff    <= '0;
         sum_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_arm_ff   <= cur_arm_in;
         played_ff    <= played_in;
         sum_ff       <= sum_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reward_ff   <= reward_in;
      q_ff        <= q_in;
      first_ff    <= first_in;
      neg_ff      <= neg_in;
      cnt_new_ff  <= cnt_new_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_est_ff <= best_est_in;
      est_res_ff  <= est_res_in;
      rsp_arm_ff  <= rsp_arm_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_next_ff <= rsp_next_in;
      rsp_sum_ff  <= rsp_sum_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_arm_played       = rsp_arm_ff;
   assign rsp_updated_estimate = rsp_est_ff;
   assign rsp_next_arm         = rsp_next_ff;
   assign rsp_total_reward     = rsp_sum_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gba_checker
   import gba_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire est_type     req_reward,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire arm_out_type rsp_arm_played,
   input wire est_type     rsp_updated_estimate,
   input wire arm_out_type rsp_next_arm,
   input wire sum_type     rsp_total_reward
);

   arm_out_type last_next_ff, last_next_in;
   logic        seen_ff, seen_in;
   arm_out_type expect_arm;
   logic        req_fire;

   assign req_fire     = req_valid && req_ready;
   assign last_next_in = (rsp_valid && rsp_ready) ? rsp_next_arm : last_next_ff;
   assign seen_in      = seen_ff || (rsp_valid && rsp_ready);
   assign expect_arm   = seen_ff ? last_next_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_next_ff <= '0;
         seen_ff      <= 1'b0;
      end else begin
         last_next_ff <= last_next_in;
         seen_ff      <= seen_in;
      end
   end

   // one request at a time: busy straight after taking one
   assert property (@(posedge clock) disable iff (reset) req_fire |=> !req_ready)
      else $error("request taken while previous one still in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_arm_played)
         && $stable(rsp_updated_estimate) && $stable(rsp_next_arm)
         && $stable(rsp_total_reward))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the reward is credited to the arm announced in the previous response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_arm_played == expect_arm)
      else $error("arm played differs from announced next arm");

endmodule

bind greedy_bandit_agent_unit gba_checker u_gba_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_reward           (req_reward),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_arm_played       (rsp_arm_played),
   .rsp_updated_estimate (rsp_updated_estimate),
   .rsp_next_arm         (rsp_next_arm),
   .rsp_total_reward     (rsp_total_reward)
);

`default_nettype wire
